// File: rtl/pcmf_pkg.sv
// Shared types and constants for the poly channel muter with fade.
package pcmf_pkg;

   localparam int DEFAULT_CHANNELS    = 16;
   localparam int DEFAULT_SAMPLE_BITS = 24;

   localparam int GAIN_BITS  = 24;
   localparam int GAIN_FRAC  = 23;
   localparam int SLOT_BITS  = 4;
   localparam int COUNT_BITS = 5;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [GAIN_BITS-1:0]  UNITY_GAIN = 24'd8388608;
   localparam logic [COUNT_BITS-1:0] MAX_SLOTS  = 5'd16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHRINK_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXCLUDE_LOW = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_STEP   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_LEVEL   = 3'd4;

   localparam logic [CSR_DATA_BITS-1:0] RAMP_STEP_RESET = 24'd1;
   localparam logic [CSR_DATA_BITS-1:0] LOW_LEVEL_RESET = 24'hB00000;

   localparam int QUEUE_DEPTH = 2;

   // Control part of one beat handed from front to back.
   typedef struct packed {
      logic                  emit;
      logic [SLOT_BITS-1:0]  slot;
      logic                  eof;
      logic [COUNT_BITS-1:0] count;
      logic [GAIN_BITS-1:0]  gain;
   } pcmf_ctl_type;

endpackage

// File: rtl/pcmf_front.sv
// Front end: config registers, per-channel mute and gain state, slot packing.
module pcmf_front #(
   parameter int CHANNELS    = pcmf_pkg::DEFAULT_CHANNELS,
   parameter int SAMPLE_BITS = pcmf_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [pcmf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pcmf_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pcmf_pkg::SLOT_BITS-1:0]        req_channel,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic                                  req_mute,
   input  logic                                  req_in_use,
   input  logic                                  req_frame_last,
   input  logic                                  queue_full,
   output logic                                  push,
   output pcmf_pkg::pcmf_ctl_type                push_ctl,
   output logic signed [SAMPLE_BITS-1:0]         push_sample
);
   import pcmf_pkg::*;

   localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic                     shrink_mode_ff;
   logic                     exclude_low_ff;
   logic                     fade_enable_ff;
   logic [GAIN_BITS-1:0]     ramp_step_ff;
   logic [CSR_DATA_BITS-1:0] low_level_ff;

   logic [GAIN_BITS-1:0]  gain_ff [CHANNELS];
   logic [GAIN_BITS-1:0]  gain_in [CHANNELS];
   logic [CHANNELS-1:0]   fading_ff, fading_in;
   logic [CHANNELS-1:0]   ramp_up_ff, ramp_up_in;
   logic [CHANNELS-1:0]   prev_mute_ff, prev_mute_in;
   logic [CHANNELS-1:0]   latest_mute_ff, latest_mute_in;
   logic                  was_shrink_ff, was_shrink_in;
   logic [COUNT_BITS-1:0] slot_count_ff, slot_count_in;

   logic [CIDX_W-1:0]          idx;
   logic                       in_range;
   logic [GAIN_BITS-1:0]       gain_sel;
   logic [GAIN_BITS+1:0]       gain_sum;
   logic [COUNT_BITS-1:0]      count_next;
   logic signed [32:0]         sample_ext;
   logic signed [32:0]         low_ext;
   logic                       above_low;

   assign idx        = req_channel[CIDX_W-1:0];
   assign in_range   = {1'b0, req_channel} < COUNT_BITS'(CHANNELS);
   assign sample_ext = 33'(req_sample);
   assign low_ext    = 33'($signed(low_level_ff));
   assign above_low  = sample_ext > low_ext;

   assign req_ready   = !queue_full;
   assign push        = req_valid && !queue_full;
   assign push_sample = req_sample;

   always_comb begin
      gain_in        = gain_ff;
      fading_in      = fading_ff;
      ramp_up_in     = ramp_up_ff;
      prev_mute_in   = prev_mute_ff;
      latest_mute_in = latest_mute_ff;
      was_shrink_in  = was_shrink_ff;
      slot_count_in  = slot_count_ff;
      gain_sel       = '0;
      gain_sum       = '0;
      count_next     = slot_count_ff;
      push_ctl       = '0;
      push_ctl.eof   = req_frame_last;

      if (push) begin
         if (!shrink_mode_ff) begin
            // snap all gains to the mute states seen while packing
            if (was_shrink_ff) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  prev_mute_in[c] = latest_mute_ff[c];
                  gain_in[c]      = latest_mute_ff[c] ? '0 : UNITY_GAIN;
               end
            end
            was_shrink_in = 1'b0;
            if (in_range) begin
               latest_mute_in[idx] = req_mute;
               if (req_mute != prev_mute_in[idx]) begin
                  if (fade_enable_ff) begin
                     fading_in[idx]  = 1'b1;
                     ramp_up_in[idx] = !req_mute;
                  end else begin
                     gain_in[idx] = req_mute ? '0 : UNITY_GAIN;
                  end
               end
               prev_mute_in[idx] = req_mute;
               gain_sel = gain_in[idx];
               if (fading_in[idx]) begin
                  if (ramp_up_in[idx]) begin
                     gain_sum = {2'b00, gain_sel} + {2'b00, ramp_step_ff};
                  end else begin
                     gain_sum = {2'b00, gain_sel} - {2'b00, ramp_step_ff};
                  end
                  // clamp an overshoot past either end and stop the ramp
                  if (gain_sum[GAIN_BITS+1]) begin
                     fading_in[idx] = 1'b0;
                     gain_in[idx]   = '0;
                  end else if (gain_sum > {2'b00, UNITY_GAIN}) begin
                     fading_in[idx] = 1'b0;
                     gain_in[idx]   = UNITY_GAIN;
                  end else begin
                     gain_in[idx] = gain_sum[GAIN_BITS-1:0];
                  end
               end
               if (req_in_use) begin
                  push_ctl.emit = 1'b1;
                  push_ctl.slot = req_channel;
                  push_ctl.gain = gain_in[idx];
               end
            end
         end else begin
            was_shrink_in = 1'b1;
            if (in_range && req_in_use) begin
               latest_mute_in[idx] = req_mute;
               if (!req_mute && (!exclude_low_ff || above_low) &&
                   (slot_count_ff < MAX_SLOTS)) begin
                  push_ctl.emit = 1'b1;
                  push_ctl.slot = slot_count_ff[SLOT_BITS-1:0];
                  push_ctl.gain = UNITY_GAIN;
               end
            end
         end

         if (push_ctl.emit && (slot_count_ff < MAX_SLOTS)) begin
            count_next = slot_count_ff + 1'b1;
         end
         push_ctl.count = count_next;
         slot_count_in  = req_frame_last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shrink_mode_ff <= 1'b0;
         exclude_low_ff <= 1'b0;
         fade_enable_ff <= 1'b1;
         ramp_step_ff   <= RAMP_STEP_RESET;
         low_level_ff   <= LOW_LEVEL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SHRINK_MODE: shrink_mode_ff <= csr_write_data[0];
            CSR_EXCLUDE_LOW: exclude_low_ff <= csr_write_data[0];
            CSR_FADE_ENABLE: fade_enable_ff <= csr_write_data[0];
            CSR_RAMP_STEP:   ramp_step_ff   <= csr_write_data[GAIN_BITS-1:0];
            CSR_LOW_LEVEL:   low_level_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            gain_ff[c] <= UNITY_GAIN;
         end
         fading_ff      <= '0;
         ramp_up_ff     <= '0;
         prev_mute_ff   <= '0;
         latest_mute_ff <= '0;
         was_shrink_ff  <= 1'b0;
         slot_count_ff  <= '0;
      end else begin
         gain_ff        <= gain_in;
         fading_ff      <= fading_in;
         ramp_up_ff     <= ramp_up_in;
         prev_mute_ff   <= prev_mute_in;
         latest_mute_ff <= latest_mute_in;
         was_shrink_ff  <= was_shrink_in;
         slot_count_ff  <= slot_count_in;
      end
   end

endmodule

// File: rtl/pcmf_queue.sv
// Two-entry queue between the front end and the multiply back end.
module pcmf_queue #(
   parameter int SAMPLE_BITS = pcmf_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  pcmf_pkg::pcmf_ctl_type         push_ctl,
   input  logic signed [SAMPLE_BITS-1:0]  push_sample,
   output logic                           full,
   input  logic                           pop,
   output logic                           head_valid,
   output pcmf_pkg::pcmf_ctl_type         head_ctl,
   output logic signed [SAMPLE_BITS-1:0]  head_sample
);
   import pcmf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   pcmf_ctl_type                  ctl_ff    [QUEUE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] sample_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]                count_ff, count_in;

   assign full        = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign head_valid  = count_ff != '0;
   assign head_ctl    = ctl_ff[rd_ptr_ff];
   assign head_sample = sample_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]    <= push_ctl;
         sample_ff[wr_ptr_ff] <= push_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/pcmf_back.sv
// Back end: gain multiply with floor shift into the result register.
module pcmf_back #(
   parameter int SAMPLE_BITS = pcmf_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  pcmf_pkg::pcmf_ctl_type              head_ctl,
   input  logic signed [SAMPLE_BITS-1:0]       head_sample,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_emit,
   output logic [pcmf_pkg::SLOT_BITS-1:0]      rsp_out_slot,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_sample,
   output logic                                rsp_end_of_frame,
   output logic [pcmf_pkg::COUNT_BITS-1:0]     rsp_out_count
);
   import pcmf_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;

   logic                          valid_ff, valid_in;
   logic                          emit_ff;
   logic [SLOT_BITS-1:0]          slot_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          eof_ff;
   logic [COUNT_BITS-1:0]         count_ff;
   logic signed [PROD_W-1:0]      product;
   logic signed [PROD_W-1:0]      scaled;

   // arithmetic shift of the signed product is a floor divide
   assign product   = head_sample * $signed({1'b0, head_ctl.gain});
   assign scaled    = product >>> GAIN_FRAC;
   assign sample_in = scaled[SAMPLE_BITS-1:0];

   // advance when the result register is empty or being taken
   assign pop      = head_valid && (!valid_ff || rsp_ready);
   assign valid_in = pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         emit_ff   <= head_ctl.emit;
         slot_ff   <= head_ctl.slot;
         sample_ff <= sample_in;
         eof_ff    <= head_ctl.eof;
         count_ff  <= head_ctl.count;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_emit         = emit_ff;
   assign rsp_out_slot     = slot_ff;
   assign rsp_out_sample   = sample_ff;
   assign rsp_end_of_frame = eof_ff;
   assign rsp_out_count    = count_ff;

endmodule

// File: rtl/poly_channel_muter_fade_top.sv
// Top level of the poly channel muter with fade.
//
// Request channel (req_): one channel sample per beat, channels 0 to 15 of a
// frame in order, with that channel's mute switch, in_use and frame_last.
// Response channel (rsp_): exactly one result beat per request beat, in
// order: emit flag, output slot, scaled or passed sample, end_of_frame echo
// and the running output count of the frame.
// Configuration (csr_): a write enable, register index and data; a write
// takes effect at the clock edge it is presented. Write only while idle.
// Throughput: one beat per cycle while the queue is not full, set by
// the front end's per-channel state update and the back end's 24x25 multiply.
// A request accepted at an edge is written into the queue at that edge and
// moves into the result register when that register is empty or being taken;
// rsp_valid then offers the result to the receiver.
// Reset clears the gains to unity, the ramps and mute history, the slot
// count and the registers to their defaults; the queue empties.
// When the receiver stalls, results wait in the result register and in the
// two-entry queue; req_ready drops only once the queue is full.
module poly_channel_muter_fade_top #(
   parameter int CHANNELS    = pcmf_pkg::DEFAULT_CHANNELS,
   parameter int SAMPLE_BITS = pcmf_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [pcmf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pcmf_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pcmf_pkg::SLOT_BITS-1:0]        req_channel,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic                                  req_mute,
   input  logic                                  req_in_use,
   input  logic                                  req_frame_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_emit,
   output logic [pcmf_pkg::SLOT_BITS-1:0]        rsp_out_slot,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_sample,
   output logic                                  rsp_end_of_frame,
   output logic [pcmf_pkg::COUNT_BITS-1:0]       rsp_out_count
);
   import pcmf_pkg::*;

   logic                          push;
   pcmf_ctl_type                  push_ctl;
   logic signed [SAMPLE_BITS-1:0] push_sample;
   logic                          queue_full;
   logic                          pop;
   logic                          head_valid;
   pcmf_ctl_type                  head_ctl;
   logic signed [SAMPLE_BITS-1:0] head_sample;

   pcmf_front #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_channel      (req_channel),
      .req_sample       (req_sample),
      .req_mute         (req_mute),
      .req_in_use       (req_in_use),
      .req_frame_last   (req_frame_last),
      .queue_full       (queue_full),
      .push             (push),
      .push_ctl         (push_ctl),
      .push_sample      (push_sample)
   );

   pcmf_queue #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_ctl    (push_ctl),
      .push_sample (push_sample),
      .full        (queue_full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_ctl    (head_ctl),
      .head_sample (head_sample)
   );

   pcmf_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_ctl         (head_ctl),
      .head_sample      (head_sample),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_emit         (rsp_emit),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_out_count    (rsp_out_count)
   );

endmodule

// File: bench/poly_channel_muter_fade_checker.sv
// Checker for the poly channel muter: predicts every result beat and compares it.
`timescale 1ns / 1ps

module poly_channel_muter_fade_checker #(
   parameter int CHANNELS    = pcmf_pkg::DEFAULT_CHANNELS,
   parameter int SAMPLE_BITS = pcmf_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [pcmf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pcmf_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [pcmf_pkg::SLOT_BITS-1:0]      req_channel,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                req_mute,
   input  logic                                req_in_use,
   input  logic                                req_frame_last,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_emit,
   input  logic [pcmf_pkg::SLOT_BITS-1:0]      rsp_out_slot,
   input  logic signed [SAMPLE_BITS-1:0]       rsp_out_sample,
   input  logic                                rsp_end_of_frame,
   input  logic [pcmf_pkg::COUNT_BITS-1:0]     rsp_out_count,
   output int                                  mismatch_count,
   output int                                  pending_results
);
   import pcmf_pkg::*;

   typedef struct packed {
      logic                   emit;
      logic [SLOT_BITS-1:0]   slot;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   eof;
      logic [COUNT_BITS-1:0]  count;
   } muted_beat_type;

   muted_beat_type expected_results[$];

   // register copies
   logic                            pack_mode;
   logic                            drop_low;
   logic                            fade_on;
   logic [CSR_DATA_BITS-1:0]        ramp_size;
   logic signed [CSR_DATA_BITS-1:0] low_cut;

   // per-channel gain and mute history
   logic [GAIN_BITS-1:0]  chan_gain [CHANNELS];
   logic                  fade_active [CHANNELS];
   logic                  fade_rising [CHANNELS];
   logic                  edge_mute [CHANNELS];
   logic                  newest_mute [CHANNELS];
   logic                  was_packing;
   logic [COUNT_BITS-1:0] slots_used;

   function automatic void clear_model();
      pack_mode = 1'b0;
      drop_low  = 1'b0;
      fade_on   = 1'b1;
      ramp_size = RAMP_STEP_RESET;
      low_cut   = LOW_LEVEL_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         chan_gain[c]   = UNITY_GAIN;
         fade_active[c] = 1'b0;
         fade_rising[c] = 1'b0;
         edge_mute[c]   = 1'b0;
         newest_mute[c] = 1'b0;
      end
      was_packing = 1'b0;
      slots_used  = '0;
   endfunction

   function automatic void apply_csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                           input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_SHRINK_MODE: pack_mode = data[0];
         CSR_EXCLUDE_LOW: drop_low  = data[0];
         CSR_FADE_ENABLE: fade_on   = data[0];
         CSR_RAMP_STEP:   ramp_size = data;
         CSR_LOW_LEVEL:   low_cut   = data;
         default: ;
      endcase
   endfunction

   // Advance the channel state for one beat and build the result it causes.
   function automatic muted_beat_type mute_fade_result(
         input logic [SLOT_BITS-1:0] ch,
         input logic signed [SAMPLE_BITS-1:0] smp,
         input logic mute,
         input logic in_use,
         input logic last);
      muted_beat_type r;
      int             g;
      longint         prod;
      r = '0;
      if (!pack_mode) begin
         // first standard beat after packing: snap every gain to its switch
         if (was_packing) begin
            for (int c = 0; c < CHANNELS; c++) begin
               edge_mute[c] = newest_mute[c];
               chan_gain[c] = newest_mute[c] ? '0 : UNITY_GAIN;
            end
         end
         was_packing = 1'b0;
         newest_mute[ch] = mute;
         if (mute != edge_mute[ch]) begin
            if (fade_on) begin
               fade_active[ch] = 1'b1;
               fade_rising[ch] = !mute;
            end else begin
               chan_gain[ch] = mute ? '0 : UNITY_GAIN;
            end
         end
         edge_mute[ch] = mute;
         if (fade_active[ch]) begin
            g = int'(chan_gain[ch]);
            g += fade_rising[ch] ? int'(ramp_size) : -int'(ramp_size);
            // exact end keeps the ramp alive; only an overshoot stops it
            if (g > int'(UNITY_GAIN)) begin
               fade_active[ch] = 1'b0;
               g = int'(UNITY_GAIN);
            end else if (g < 0) begin
               fade_active[ch] = 1'b0;
               g = 0;
            end
            chan_gain[ch] = g[GAIN_BITS-1:0];
         end
         if (in_use) begin
            prod = longint'(smp) * longint'(chan_gain[ch]);
            prod = prod >>> GAIN_FRAC;
            r.emit   = 1'b1;
            r.slot   = ch;
            r.sample = prod[SAMPLE_BITS-1:0];
         end
      end else begin
         was_packing = 1'b1;
         if (in_use) begin
            newest_mute[ch] = mute;
            if (!mute && (!drop_low || smp > low_cut) && slots_used < MAX_SLOTS) begin
               r.emit   = 1'b1;
               r.slot   = slots_used[SLOT_BITS-1:0];
               r.sample = smp;
            end
         end
      end
      if (r.emit && slots_used < MAX_SLOTS)
         slots_used = slots_used + 1'b1;
      r.eof   = last;
      r.count = slots_used;
      if (last)
         slots_used = '0;
      return r;
   endfunction

   task automatic note_mismatch(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch_beats
      muted_beat_type want;
      if (reset) begin
         clear_model();
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual slot %0d sample %0d",
                        $time, rsp_out_slot, rsp_out_sample);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_emit !== want.emit)
                  note_mismatch("emit", want.emit, rsp_emit);
               if (rsp_out_slot !== want.slot)
                  note_mismatch("out_slot", want.slot, rsp_out_slot);
               if (rsp_out_sample !== want.sample)
                  note_mismatch("out_sample", $signed(want.sample), rsp_out_sample);
               if (rsp_end_of_frame !== want.eof)
                  note_mismatch("end_of_frame", want.eof, rsp_end_of_frame);
               if (rsp_out_count !== want.count)
                  note_mismatch("out_count", want.count, rsp_out_count);
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(mute_fade_result(req_channel, req_sample, req_mute,
                                                        req_in_use, req_frame_last));
         // a write takes effect for beats after this edge
         if (csr_write_enable)
            apply_csr_write(csr_index, csr_write_data);
      end
      pending_results = expected_results.size();
   end

endmodule

// File: bench/poly_channel_muter_fade_top_test.sv
// Testbench top for the poly channel muter: drives frames and settings, gives the verdict.
`timescale 1ns / 1ps

module poly_channel_muter_fade_top_test;
   import pcmf_pkg::*;

   localparam int CHANNELS       = DEFAULT_CHANNELS;
   localparam int SAMPLE_BITS    = DEFAULT_SAMPLE_BITS;
   localparam int DIRECTED_BEATS = 23;
   localparam int RANDOM_BEATS   = 600;
   localparam int QUIET_LIMIT    = 1000;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_write_data;
   logic                          req_valid;
   logic                          req_ready;
   logic [SLOT_BITS-1:0]          req_channel;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          req_mute;
   logic                          req_in_use;
   logic                          req_frame_last;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_emit;
   logic [SLOT_BITS-1:0]          rsp_out_slot;
   logic signed [SAMPLE_BITS-1:0] rsp_out_sample;
   logic                          rsp_end_of_frame;
   logic [COUNT_BITS-1:0]         rsp_out_count;

   int mismatch_count;
   int pending_results;
   int idle_pct = 6;
   int stall_pct = 6;
   int beats_sent = 0;
   int quiet_cycles;

   logic                            mute_switch [CHANNELS];
   logic signed [CSR_DATA_BITS-1:0] low_now;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   poly_channel_muter_fade_top #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_channel      (req_channel),
      .req_sample       (req_sample),
      .req_mute         (req_mute),
      .req_in_use       (req_in_use),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_emit         (rsp_emit),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_out_count    (rsp_out_count)
   );

   poly_channel_muter_fade_checker #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_channel      (req_channel),
      .req_sample       (req_sample),
      .req_mute         (req_mute),
      .req_in_use       (req_in_use),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_emit         (rsp_emit),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_out_count    (rsp_out_count),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results)
   );

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin : watchdog
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("poly_channel_muter_fade_top_test: done, errors");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic [SLOT_BITS-1:0] ch,
                            input logic signed [SAMPLE_BITS-1:0] smp,
                            input logic mute, input logic in_use, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_channel    <= ch;
      req_sample     <= smp;
      req_mute       <= mute;
      req_in_use     <= in_use;
      req_frame_last <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // Drain the block, then write all five registers.
   task automatic write_settings(input logic shrink, input logic excl, input logic fade,
                                 input logic [CSR_DATA_BITS-1:0] step,
                                 input logic [CSR_DATA_BITS-1:0] low);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0)
         @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SHRINK_MODE;
      csr_write_data <= CSR_DATA_BITS'(shrink);
      @(negedge clock);
      csr_index <= CSR_EXCLUDE_LOW;
      csr_write_data <= CSR_DATA_BITS'(excl);
      @(negedge clock);
      csr_index <= CSR_FADE_ENABLE;
      csr_write_data <= CSR_DATA_BITS'(fade);
      @(negedge clock);
      csr_index <= CSR_RAMP_STEP;
      csr_write_data <= step;
      @(negedge clock);
      csr_index <= CSR_LOW_LEVEL;
      csr_write_data <= low;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      low_now = low;
   endtask

   // Lean toward the exclusion threshold and the range ends.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0: return low_now;
         1: return low_now + 1'b1;
         2: return low_now - 1'b1;
         3: return SAMPLE_MAX;
         4: return SAMPLE_MIN;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic send_frame();
      int used;
      used = $urandom_range(CHANNELS);
      for (int c = 0; c < CHANNELS; c++) begin
         if ($urandom_range(99) < 15)
            mute_switch[c] = !mute_switch[c];
         send_beat(SLOT_BITS'(c), pick_sample(), mute_switch[c], c < used, c == CHANNELS - 1);
      end
   endtask

   // Long frame with mostly live channels: drives the slot count into saturation.
   task automatic send_runon();
      int n;
      n = $urandom_range(24, 17);
      for (int i = 0; i < n; i++)
         send_beat(SLOT_BITS'($urandom), pick_sample(), $urandom_range(99) < 10,
                   $urandom_range(99) < 90, i == n - 1);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(16, 4);
      repeat (n)
         send_beat(SLOT_BITS'($urandom), SAMPLE_BITS'($urandom), 1'($urandom_range(1)),
                   1'($urandom_range(1)), $urandom_range(7) == 0);
   endtask

   task automatic random_settings();
      logic [CSR_DATA_BITS-1:0] step;
      logic [CSR_DATA_BITS-1:0] low;
      case ($urandom_range(6))
         0: step = '0;
         1: step = CSR_DATA_BITS'(1);
         2: step = UNITY_GAIN;
         3: step = UNITY_GAIN >> 1;
         4: step = CSR_DATA_BITS'($urandom_range(UNITY_GAIN, 1));
         default: step = CSR_DATA_BITS'($urandom_range(1 << 21, 1 << 16));
      endcase
      case ($urandom_range(5))
         0: low = SAMPLE_MIN;
         1: low = SAMPLE_MAX;
         2: low = LOW_LEVEL_RESET;
         3: low = '0;
         default: low = CSR_DATA_BITS'($urandom);
      endcase
      write_settings($urandom_range(99) < 35, 1'($urandom_range(1)), $urandom_range(99) < 80,
                     step, low);
   endtask

   initial begin : stimulus
      int pick;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SHRINK_MODE;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_channel      = '0;
      req_sample       = '0;
      req_mute         = 1'b0;
      req_in_use       = 1'b0;
      req_frame_last   = 1'b0;
      low_now          = LOW_LEVEL_RESET;
      for (int c = 0; c < CHANNELS; c++)
         mute_switch[c] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: unity gain at the sample extremes, slow fade, unused lanes
      send_beat(SLOT_BITS'(0), SAMPLE_MAX, 1'b0, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(1), SAMPLE_MIN, 1'b0, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(2), '1, 1'b0, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(3), '0, 1'b0, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(4), SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(5), SAMPLE_MAX, 1'b1, 1'b0, 1'b0);
      send_beat(SLOT_BITS'(6), SAMPLE_MIN, 1'b0, 1'b0, 1'b1);
      send_beat(SLOT_BITS'(0), SAMPLE_MAX, 1'b0, 1'b0, 1'b1);

      // half-unity step: ramp lands exactly on the ends, then overshoots and clamps
      write_settings(1'b0, 1'b0, 1'b1, UNITY_GAIN >> 1, '0);
      repeat (4)
         send_beat(SLOT_BITS'(7), SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
      repeat (3)
         send_beat(SLOT_BITS'(7), SAMPLE_MIN, 1'b0, 1'b1, 1'b0);

      // fades off: gain jumps
      write_settings(1'b0, 1'b0, 1'b0, UNITY_GAIN >> 1, '0);
      send_beat(SLOT_BITS'(7), SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(8), SAMPLE_MIN, 1'b1, 1'b1, 1'b1);

      // packing with exclusion at zero
      write_settings(1'b1, 1'b1, 1'b1, UNITY_GAIN >> 1, '0);
      send_beat(SLOT_BITS'(0), '0, 1'b0, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(1), SAMPLE_BITS'(1), 1'b0, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(2), SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(3), SAMPLE_MAX, 1'b0, 1'b0, 1'b0);
      send_beat(SLOT_BITS'(4), SAMPLE_MIN, 1'b0, 1'b1, 1'b0);
      send_beat(SLOT_BITS'(5), SAMPLE_MAX, 1'b0, 1'b1, 1'b1);

      while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
         // one stretch with neither side idling
         idle_pct  = (beats_sent > 300 && beats_sent < 450) ? 0 : 6;
         stall_pct = idle_pct;
         random_settings();
         repeat ($urandom_range(5, 2)) begin
            pick = $urandom_range(9);
            if (pick < 8)
               send_frame();
            else if (pick == 8)
               send_runon();
            else
               send_noise();
         end
      end

      req_valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("poly_channel_muter_fade_top_test: done, clean");
      else
         $display("poly_channel_muter_fade_top_test: done, errors");
      $finish;
   end

endmodule

// File: poly_channel_muter_fade_top.f
rtl/pcmf_pkg.sv
rtl/pcmf_front.sv
rtl/pcmf_queue.sv
rtl/pcmf_back.sv
rtl/poly_channel_muter_fade_top.sv
bench/poly_channel_muter_fade_checker.sv
bench/poly_channel_muter_fade_top_test.sv
